@@ rtl/tmcw_pkg.sv @@
// package for the text mode console writer
// holds geometry defaults, operation codes, controller states and the
// command/status structs shared by the controller and the datapath
package tmcw_pkg;

	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF = 25;
	localparam int unsigned COL_W = 7;
	localparam int unsigned ROW_W = 5;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned ATTR_W = 8;
	localparam int unsigned CELL_W = CHAR_W + ATTR_W;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;

	typedef enum logic [1:0] {
		OP_PUT_CHAR = 2'd0,
		OP_PUT_HEX  = 2'd1,
		OP_SET_CUR  = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEX,
		ST_SCROLL,
		ST_READ,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the input item
		logic put_char;   // put the captured character
		logic put_hex;    // put the current hex digit and step the digit count
		logic set_cur;    // set cursor from the target
		logic read_req;   // issue the cell read
		logic clear_cell; // write one blank cell in the row being cleared
		logic clear_all;  // post-reset clear sweep step
		logic respond;    // drive the result strobe
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scroll_pending; // a row must be cleared
		logic clear_last;     // last cell of the current clear sweep
		logic hex_none;       // no hex digits left
	} dp_status_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
		if (d < 4'd10)
			return CHAR_W'(8'h30 + {4'd0, d});
		return CHAR_W'(8'h41 + {4'd0, d} - 8'd10);
	endfunction

endpackage

@@ rtl/text_mode_console_writer.sv @@
// text mode console writer top level: controller, datapath, attribute register
// depends on tmcw_pkg, tmcw_ctrl, tmcw_dp
//
// An item is taken when start is high and busy is low; its single result
// shows for one cycle with done high, and the receiver cannot stall it.
// A scroll clears the new bottom row one cell per cycle through the single
// store port. After reset the store is swept clear with busy high.
module text_mode_console_writer import tmcw_pkg::*; #(
	parameter int unsigned COLUMNS = COLUMNS_DEF,
	parameter int unsigned ROWS = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic              attr_we,
	input  logic [ATTR_W-1:0] attr_wdata,
	input  logic [1:0]        op,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [31:0]       hex_value,
	input  logic [3:0]        hex_digits,
	input  logic [COL_W-1:0]  target_col,
	input  logic [ROW_W-1:0]  target_row,
	output logic [COL_W-1:0]  cursor_col_out,
	output logic [ROW_W-1:0]  cursor_row_out,
	output logic [CHAR_W-1:0] cell_char,
	output logic [ATTR_W-1:0] cell_attr
);
	dp_cmd_t cmd;
	dp_status_t sts;
	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	logic [CHAR_W-1:0] cc;
	logic [ATTR_W-1:0] ca;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			attr_q <= ATTR_RESET;
		else if (attr_we)
			attr_q <= attr_wdata;
	end

	tmcw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	tmcw_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .attr(attr_q),
		.char_code(char_code), .hex_value(hex_value), .hex_digits(hex_digits),
		.target_col(target_col), .target_row(target_row),
		.cursor_col(col), .cursor_row(row), .cell_char(cc), .cell_attr(ca)
	);

	assign done = cmd.respond;
	assign cursor_col_out = col;
	assign cursor_row_out = row;
	assign cell_char = cc;
	assign cell_attr = ca;
endmodule

@@ rtl/tmcw_ram.sv @@
// generic single port ram with registered read
// no dependencies
module tmcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

@@ rtl/tmcw_ctrl.sv @@
// controller state machine of the console writer
// depends on tmcw_pkg
module tmcw_ctrl import tmcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] op,
	input  dp_status_t sts,
	output dp_cmd_t    cmd,
	output logic       busy
);
	state_t state_q, state_d;
	op_t op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			op_q <= OP_PUT_CHAR;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start)
				op_q <= op_t'(op);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_all = 1'b1;
				if (sts.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					case (op_t'(op))
						OP_PUT_CHAR: state_d = ST_HEX;
						OP_PUT_HEX:  state_d = ST_HEX;
						OP_SET_CUR:  state_d = ST_DONE;
						default:     state_d = ST_READ;
					endcase
				end
			end
			ST_HEX: begin
				if (op_q == OP_PUT_CHAR) begin
					cmd.put_char = 1'b1;
					state_d = ST_SCROLL;
				end else if (sts.hex_none) begin
					state_d = ST_DONE;
				end else begin
					cmd.put_hex = 1'b1;
					state_d = ST_SCROLL;
				end
			end
			ST_SCROLL: begin
				if (sts.scroll_pending) begin
					cmd.clear_cell = 1'b1;
					if (sts.clear_last)
						state_d = (op_q == OP_PUT_HEX && !sts.hex_none) ? ST_HEX : ST_DONE;
				end else begin
					state_d = (op_q == OP_PUT_HEX && !sts.hex_none) ? ST_HEX : ST_DONE;
				end
			end
			ST_READ: begin
				cmd.read_req = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (op_q == OP_SET_CUR)
					cmd.set_cur = 1'b1;
				cmd.respond = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

@@ rtl/tmcw_dp.sv @@
// datapath of the console writer: cursor, ring top, hex digits, cell store
// depends on tmcw_pkg and tmcw_ram
module tmcw_dp import tmcw_pkg::*; #(
	parameter int unsigned COLUMNS = COLUMNS_DEF,
	parameter int unsigned ROWS = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_status_t        sts,
	input  logic [ATTR_W-1:0] attr,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [31:0]       hex_value,
	input  logic [3:0]        hex_digits,
	input  logic [COL_W-1:0]  target_col,
	input  logic [ROW_W-1:0]  target_row,
	output logic [COL_W-1:0]  cursor_col,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [CHAR_W-1:0] cell_char,
	output logic [ATTR_W-1:0] cell_attr
);
	localparam int unsigned DEPTH = COLUMNS * ROWS;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(COLUMNS);
	localparam int unsigned RW = $clog2(ROWS);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q, top_q;
	logic [CHAR_W-1:0] ch_q;
	logic [31:0] hex_q;
	logic [3:0] cnt_q;
	logic [CW-1:0] tcol_q;
	logic [RW-1:0] trow_q;
	logic scroll_q, rd_q;
	logic [CW-1:0] ccol_q;
	logic [AW-1:0] sweep_q;

	logic [AW-1:0] addr;
	logic we;
	logic [CELL_W-1:0] wdata, rdata;

	// ring row mapping
	function automatic logic [RW-1:0] phys(input logic [RW-1:0] top, input logic [RW-1:0] r);
		logic [RW:0] s;
		s = {1'b0, top} + {1'b0, r};
		if (s >= (RW+1)'(ROWS))
			s = s - (RW+1)'(ROWS);
		return s[RW-1:0];
	endfunction

	logic [CHAR_W-1:0] put_ch;
	logic is_nl;
	logic [AW-1:0] cur_addr, rd_addr, clr_addr;
	logic [CW:0] col_inc;

	always_comb begin
		put_ch = cmd.put_hex ? hex_char(hex_q[31:28]) : ch_q;
		is_nl = cmd.put_char && (ch_q == NEWLINE_CODE);
		cur_addr = AW'(phys(top_q, row_q) * COLUMNS) + AW'(col_q);
		rd_addr = AW'(phys(top_q, trow_q) * COLUMNS) + AW'(tcol_q);
		clr_addr = AW'(top_q * COLUMNS) + AW'(ccol_q);
		col_inc = {1'b0, col_q} + 1'b1;
		we = 1'b0;
		addr = cur_addr;
		wdata = {attr, put_ch};
		if (cmd.clear_all) begin
			we = 1'b1;
			addr = sweep_q;
			wdata = '0;
		end else if (cmd.clear_cell) begin
			we = 1'b1;
			addr = clr_addr;
			wdata = {attr, CHAR_W'(0)};
		end else if ((cmd.put_char && !is_nl) || cmd.put_hex) begin
			we = 1'b1;
		end else if (cmd.read_req) begin
			addr = rd_addr;
		end
	end

	tmcw_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_comb begin
		sts.scroll_pending = scroll_q;
		sts.clear_last = cmd.clear_all ? (sweep_q == AW'(DEPTH - 1))
			: (ccol_q == CW'(COLUMNS - 1));
		sts.hex_none = (cnt_q == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			top_q <= '0;
			scroll_q <= 1'b0;
			ccol_q <= '0;
			sweep_q <= '0;
			cnt_q <= '0;
			rd_q <= 1'b0;
		end else begin
			rd_q <= cmd.read_req;
			if (cmd.clear_all)
				sweep_q <= sweep_q + 1'b1;
			if (cmd.load)
				cnt_q <= (hex_digits > 4'd8) ? 4'd8 : hex_digits;
			else if (cmd.put_hex)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.clear_cell) begin
				if (ccol_q == CW'(COLUMNS - 1)) begin
					ccol_q <= '0;
					scroll_q <= 1'b0;
					top_q <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
				end else begin
					ccol_q <= ccol_q + 1'b1;
				end
			end
			if (cmd.put_char || cmd.put_hex) begin
				if (is_nl || col_inc >= (CW+1)'(COLUMNS)) begin
					col_q <= '0;
					if (row_q == RW'(ROWS - 1))
						scroll_q <= 1'b1;
					else
						row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
			if (cmd.set_cur) begin
				col_q <= tcol_q;
				row_q <= trow_q;
			end
		end
	end

	// input item capture, saturated targets
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q <= char_code;
			hex_q <= (hex_digits >= 4'd8) ? hex_value
				: hex_value << (6'd32 - {hex_digits[2:0], 2'b00});
			tcol_q <= (target_col > COL_W'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(target_col);
			trow_q <= (target_row > ROW_W'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(target_row);
		end else if (cmd.put_hex) begin
			hex_q <= hex_q << 4;
		end
	end

	logic [CHAR_W-1:0] rc_q;
	logic [ATTR_W-1:0] ra_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rc_q <= '0;
			ra_q <= '0;
		end else if (rd_q) begin
			rc_q <= rdata[CHAR_W-1:0];
			ra_q <= rdata[CELL_W-1:CHAR_W];
		end
	end

	assign cursor_col = (cmd.set_cur) ? COL_W'(tcol_q) : COL_W'(col_q);
	assign cursor_row = (cmd.set_cur) ? ROW_W'(trow_q) : ROW_W'(row_q);
	assign cell_char = rd_q ? rdata[CHAR_W-1:0] : rc_q;
	assign cell_attr = rd_q ? rdata[CELL_W-1:CHAR_W] : ra_q;
endmodule

@@ rtl/tmcw_checker.sv @@
// port level checker for the console writer, bound to the top level
// depends on tmcw_pkg
module tmcw_sva import tmcw_pkg::*; #(
	parameter int unsigned COLUMNS = COLUMNS_DEF,
	parameter int unsigned ROWS = ROWS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [COL_W-1:0] cursor_col_out,
	input logic [ROW_W-1:0] cursor_row_out
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result while idle");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_cur_col: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(cursor_col_out) < COLUMNS) else $error("cursor column out of range");
	a_cur_row: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(cursor_row_out) < ROWS) else $error("cursor row out of range");
endmodule

bind text_mode_console_writer tmcw_sva #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tmcw_sva (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cursor_col_out(cursor_col_out), .cursor_row_out(cursor_row_out)
);
